// ----- hdl/mstp_pkg.sv -----
// Package for the maximum spanning tree engine: sizes, payload words,
// memory entry layouts, controller state codes and the pair address helper.
// No dependencies.
`default_nettype none

package mstp_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int WEIGHT_BITS  = 16;

    localparam int VIDX_W    = $clog2(MAX_VERTICES);
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
    localparam int MAT_AW    = 2 * VIDX_W;
    localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int TOTAL_W   = WEIGHT_BITS + VIDX_W;

    // configuration port
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;
    localparam int VCOUNT_W = 6;
    localparam logic [PADDR_W-1:0]  ADDR_VCOUNT  = '0;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t         operation;
        logic [4:0]  vertex_a;
        logic [4:0]  vertex_b;
        logic [15:0] edge_weight;
    } req_t;

    typedef struct packed
    {
        logic [4:0]  vertex;
        logic [4:0]  parent;
        logic [15:0] tree_weight;
        logic        reached;
        logic [20:0] total_weight;
        logic        last;
    } rsp_t;

    // one weight matrix entry, stored once per unordered vertex pair
    typedef struct packed
    {
        logic                   present;
        logic [WEIGHT_BITS-1:0] weight;
    } mat_t;

    // one per-vertex entry of the tree state memory
    typedef struct packed
    {
        logic                   visited;
        logic                   key_ok;
        logic [WEIGHT_BITS-1:0] key_val;
        logic [VIDX_W-1:0]      parent;
    } vert_t;

    // matrix port request from the tree controller
    typedef struct packed
    {
        logic              rd_en;
        logic [MAT_AW-1:0] rd_addr;
        logic              wr_en;
        logic [MAT_AW-1:0] wr_addr;
        mat_t              wr_data;
    } mat_req_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SELECT,
        ST_RELAX,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // matrix address of an unordered pair: {smaller, larger}
    function automatic logic [MAT_AW-1:0] pair_addr(input logic [VIDX_W-1:0] a,
                                                     input logic [VIDX_W-1:0] b);
        logic [MAT_AW-1:0] addr;
        if (a < b)
        begin
            addr = {a, b};
        end
        else
        begin
            addr = {b, a};
        end
        return addr;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mstp_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered
// read data, held when no read is issued. No dependencies.
`default_nettype none

module mstp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mstp_ctrl.sv -----
// Tree controller: matrix clear sweep, per-run vertex state init, select and
// relax rounds over the vertex memory, result emission into the output word.
// Depends on mstp_pkg and mstp_ram.
`default_nettype none

module mstp_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mstp_pkg::CNT_W-1:0] n,
    output logic                            busy,
    output mstp_pkg::mat_req_t              mat_req,
    input  wire mstp_pkg::mat_t             mat_rdata,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output mstp_pkg::rsp_t                  rsp_data
);

    localparam int W  = mstp_pkg::WEIGHT_BITS;
    localparam int VW = mstp_pkg::VIDX_W;
    localparam int CW = mstp_pkg::CNT_W;
    localparam int TW = mstp_pkg::TOTAL_W;

    mstp_pkg::state_t state_reg, state_next;

    logic [CW-1:0]               issue_idx_reg;
    logic                        d_vld_reg;
    logic [VW-1:0]               d_idx_reg;
    logic [mstp_pkg::MAT_AW-1:0] clr_idx_reg;
    logic                        found_reg;
    logic [W-1:0]                best_reg;
    logic [VW-1:0]               pick_reg;
    logic [TW-1:0]               total_reg;
    logic                        rsp_valid_reg;
    mstp_pkg::rsp_t              rsp_reg;

    // vertex memory port
    logic            v_we;
    logic [VW-1:0]   v_waddr;
    mstp_pkg::vert_t v_wdata;
    logic            v_re;
    logic [VW-1:0]   v_raddr;
    mstp_pkg::vert_t v_rdata;

    mstp_ram #(
        .DEPTH (mstp_pkg::MAX_VERTICES),
        .WIDTH ($bits(mstp_pkg::vert_t))
    ) u_vmem (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    logic            issue_ok;
    logic            last_data;
    logic            cand;
    logic            found_now;
    logic            relax_hit;
    mstp_pkg::vert_t rel_entry;
    mstp_pkg::vert_t init_entry;
    logic            out_free;
    logic            emit_last;
    logic [W-1:0]    add_w;
    logic [TW-1:0]   sum;

    always_comb
    begin
        issue_ok  = issue_idx_reg < n;
        last_data = d_vld_reg && (CW'(d_idx_reg) == (n - CW'(1)));
        cand      = d_vld_reg && !v_rdata.visited && v_rdata.key_ok &&
                    (!found_reg || (v_rdata.key_val > best_reg));
        found_now = found_reg || cand;

        // raise the key of an unvisited neighbour when the edge is heavier
        relax_hit = mat_rdata.present && !v_rdata.visited &&
                    (!v_rdata.key_ok || (v_rdata.key_val < mat_rdata.weight));
        rel_entry = v_rdata;
        if (d_idx_reg == pick_reg)
        begin
            rel_entry.visited = 1'b1;
        end
        else if (relax_hit)
        begin
            rel_entry.key_ok  = 1'b1;
            rel_entry.key_val = mat_rdata.weight;
            rel_entry.parent  = pick_reg;
        end

        init_entry        = '0;
        init_entry.key_ok = (issue_idx_reg == '0);

        out_free  = !rsp_valid_reg || !rsp_stall;
        emit_last = issue_idx_reg == (n - CW'(1));
        add_w     = v_rdata.key_ok ? v_rdata.key_val : '0;
        sum       = total_reg + TW'(add_w);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mstp_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == '1)
                begin
                    state_next = mstp_pkg::ST_IDLE;
                end
            end
            mstp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mstp_pkg::ST_INIT;
                end
            end
            mstp_pkg::ST_INIT:
            begin
                if (issue_idx_reg == CW'(mstp_pkg::MAX_VERTICES - 1))
                begin
                    state_next = mstp_pkg::ST_SELECT;
                end
            end
            mstp_pkg::ST_SELECT:
            begin
                if (last_data)
                begin
                    state_next = found_now ? mstp_pkg::ST_RELAX : mstp_pkg::ST_EMIT_RD;
                end
            end
            mstp_pkg::ST_RELAX:
            begin
                if (last_data)
                begin
                    state_next = mstp_pkg::ST_SELECT;
                end
            end
            mstp_pkg::ST_EMIT_RD:
            begin
                state_next = mstp_pkg::ST_EMIT_LD;
            end
            mstp_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? mstp_pkg::ST_CLEAR : mstp_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = mstp_pkg::ST_CLEAR;
            end
        endcase
    end

    // memory requests
    always_comb
    begin
        v_we    = 1'b0;
        v_waddr = '0;
        v_wdata = '0;
        v_re    = 1'b0;
        v_raddr = issue_idx_reg[VW-1:0];
        mat_req = '0;
        busy    = state_reg != mstp_pkg::ST_IDLE;
        unique case (state_reg)
            mstp_pkg::ST_CLEAR:
            begin
                mat_req.wr_en   = 1'b1;
                mat_req.wr_addr = clr_idx_reg;
            end
            mstp_pkg::ST_IDLE:
            begin
            end
            mstp_pkg::ST_INIT:
            begin
                v_we    = 1'b1;
                v_waddr = issue_idx_reg[VW-1:0];
                v_wdata = init_entry;
            end
            mstp_pkg::ST_SELECT:
            begin
                v_re = issue_ok;
            end
            mstp_pkg::ST_RELAX:
            begin
                v_re            = issue_ok;
                mat_req.rd_en   = issue_ok;
                mat_req.rd_addr = mstp_pkg::pair_addr(pick_reg, issue_idx_reg[VW-1:0]);
                v_we            = d_vld_reg;
                v_waddr         = d_idx_reg;
                v_wdata         = rel_entry;
            end
            mstp_pkg::ST_EMIT_RD:
            begin
                v_re = 1'b1;
            end
            mstp_pkg::ST_EMIT_LD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstp_pkg::ST_CLEAR;
            issue_idx_reg <= '0;
            d_vld_reg     <= 1'b0;
            d_idx_reg     <= '0;
            clr_idx_reg   <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            pick_reg      <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            d_vld_reg <= 1'b0;
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                mstp_pkg::ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
                mstp_pkg::ST_IDLE:
                begin
                    issue_idx_reg <= '0;
                    total_reg     <= '0;
                end
                mstp_pkg::ST_INIT:
                begin
                    found_reg <= 1'b0;
                    if (issue_idx_reg == CW'(mstp_pkg::MAX_VERTICES - 1))
                    begin
                        issue_idx_reg <= '0;
                    end
                    else
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                end
                mstp_pkg::ST_SELECT:
                begin
                    if (issue_ok)
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                    d_vld_reg <= issue_ok;
                    d_idx_reg <= issue_idx_reg[VW-1:0];
                    if (cand)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= v_rdata.key_val;
                        pick_reg  <= d_idx_reg;
                    end
                    if (last_data)
                    begin
                        found_reg     <= 1'b0;
                        // emission starts at vertex 1
                        issue_idx_reg <= found_now ? '0 : CW'(1);
                    end
                end
                mstp_pkg::ST_RELAX:
                begin
                    if (issue_ok)
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                    d_vld_reg <= issue_ok;
                    d_idx_reg <= issue_idx_reg[VW-1:0];
                    if (last_data)
                    begin
                        issue_idx_reg <= '0;
                    end
                end
                mstp_pkg::ST_EMIT_RD:
                begin
                end
                mstp_pkg::ST_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        total_reg     <= sum;
                        issue_idx_reg <= emit_last ? '0 : issue_idx_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == mstp_pkg::ST_EMIT_LD) && out_free)
        begin
            rsp_reg.vertex       <= 5'(issue_idx_reg);
            rsp_reg.parent       <= v_rdata.key_ok ? 5'(v_rdata.parent) : 5'd0;
            rsp_reg.tree_weight  <= 16'(add_w);
            rsp_reg.reached      <= v_rdata.key_ok;
            rsp_reg.total_weight <= emit_last ? 21'(sum) : 21'd0;
            rsp_reg.last         <= emit_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

// ----- hdl/max_spanning_tree_prim_top.sv -----
// Top level of the maximum spanning tree engine: configuration register,
// edge load pipeline with forwarding, weight matrix memory, tree controller.
// Depends on mstp_pkg, mstp_ram and mstp_ctrl.
//
//  channel  | handshake          | word    | direction
//  ---------+--------------------+---------+----------
//  req      | req_valid/req_stall| req_t   | in
//  rsp      | rsp_valid/rsp_stall| rsp_t   | out
//  config   | APB psel/penable   | 32 bits | in/out
//
// Reset runs a clearing pass over the 1024-entry weight matrix, one entry a
// cycle, with req_stall high; the same pass follows every run. Edge loads
// can be taken back to back: a read at acceptance, a compare-and-write the
// next cycle, with the last write forwarded to a load of the same pair.
// A start word runs a state init of every vertex entry, then up to n rounds
// for n vertices, each one select sweep and one relax sweep through the
// vertex memory port, then a closing select sweep, then a read and a load
// of the output word per result, and then the clearing pass.
// rsp_stall only holds the output word; the controller waits on it.
`default_nettype none

module max_spanning_tree_prim_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mstp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mstp_pkg::PDATA_W-1:0] pwdata,
    output logic      [mstp_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    // edge and start words
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire mstp_pkg::req_t               req_data,
    // tree edge results
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output mstp_pkg::rsp_t                    rsp_data
);

    localparam int VW = mstp_pkg::VIDX_W;
    localparam int CW = mstp_pkg::CNT_W;
    localparam int AW = mstp_pkg::MAT_AW;
    localparam int W  = mstp_pkg::WEIGHT_BITS;

    // ---------------- configuration ----------------
    logic [mstp_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [CW-1:0]                 n;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == mstp_pkg::ADDR_VCOUNT);
    assign prdata = (paddr == mstp_pkg::ADDR_VCOUNT) ?
                    mstp_pkg::PDATA_W'(vcount_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= mstp_pkg::VCOUNT_RESET;
        end
        else if (cfg_wr)
        begin
            vcount_reg <= pwdata[mstp_pkg::VCOUNT_W-1:0];
        end
    end

    // vertex count saturates into [2, MAX_VERTICES]
    always_comb
    begin
        if (32'(vcount_reg) < 32'd2)
        begin
            n = CW'(2);
        end
        else if (32'(vcount_reg) > 32'(mstp_pkg::MAX_VERTICES))
        begin
            n = CW'(mstp_pkg::MAX_VERTICES);
        end
        else
        begin
            n = CW'(vcount_reg);
        end
    end

    // ---------------- request decode ----------------
    logic req_acc;
    logic start;
    logic ld_ok;

    assign req_acc = req_valid && !req_stall;
    assign start   = req_acc && (req_data.operation == mstp_pkg::OP_START);
    // out-of-range endpoints and self loops are dropped here
    assign ld_ok   = req_acc && (req_data.operation == mstp_pkg::OP_LOAD) &&
                     (CW'(req_data.vertex_a) < n) && (CW'(req_data.vertex_b) < n) &&
                     (req_data.vertex_a != req_data.vertex_b);

    // ---------------- edge load stage ----------------
    logic          ld_vld_reg;
    logic [AW-1:0] ld_addr_reg;
    logic [W-1:0]  ld_w_reg;
    logic          fwd_vld_reg;
    logic [AW-1:0] fwd_addr_reg;
    mstp_pkg::mat_t fwd_data_reg;

    mstp_pkg::mat_t mat_rdata;
    mstp_pkg::mat_t ld_old;
    mstp_pkg::mat_t ld_new;
    logic           ld_wr;

    always_comb
    begin
        // the previous cycle's write is not yet visible in the read data
        ld_old = (fwd_vld_reg && (fwd_addr_reg == ld_addr_reg)) ? fwd_data_reg : mat_rdata;
        ld_wr  = ld_vld_reg && (!ld_old.present || (ld_old.weight < ld_w_reg));
        ld_new = ld_old;
        if (ld_wr)
        begin
            ld_new.present = 1'b1;
            ld_new.weight  = ld_w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            ld_vld_reg  <= ld_ok;
            fwd_vld_reg <= ld_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_addr_reg  <= mstp_pkg::pair_addr(req_data.vertex_a[VW-1:0],
                                            req_data.vertex_b[VW-1:0]);
        ld_w_reg     <= req_data.edge_weight[W-1:0];
        fwd_addr_reg <= ld_addr_reg;
        fwd_data_reg <= ld_new;
    end

    // ---------------- weight matrix ----------------
    mstp_pkg::mat_req_t ctrl_req;
    logic               ctrl_busy;
    logic               m_we;
    logic [AW-1:0]      m_waddr;
    mstp_pkg::mat_t     m_wdata;
    logic               m_re;
    logic [AW-1:0]      m_raddr;

    always_comb
    begin
        m_we    = ld_wr || ctrl_req.wr_en;
        m_waddr = ld_wr ? ld_addr_reg : ctrl_req.wr_addr;
        m_wdata = ld_wr ? ld_new : ctrl_req.wr_data;
        m_re    = ld_ok || ctrl_req.rd_en;
        m_raddr = ctrl_req.rd_en ? ctrl_req.rd_addr :
                  mstp_pkg::pair_addr(req_data.vertex_a[VW-1:0], req_data.vertex_b[VW-1:0]);
    end

    mstp_ram #(
        .DEPTH (mstp_pkg::MAT_DEPTH),
        .WIDTH ($bits(mstp_pkg::mat_t))
    ) u_matrix (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (mat_rdata)
    );

    // ---------------- tree controller ----------------
    mstp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .n         (n),
        .busy      (ctrl_busy),
        .mat_req   (ctrl_req),
        .mat_rdata (mat_rdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    assign req_stall = ctrl_busy;

endmodule

`default_nettype wire

// ----- hdl/mstp_chk.sv -----
// Port-level checker for the maximum spanning tree engine, bound to the top.
// Depends on mstp_pkg.
`default_nettype none

module mstp_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire mstp_pkg::req_t req_data,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire mstp_pkg::rsp_t rsp_data
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result word changed");

    // unreached vertices report no parent and no weight
    a_unreached: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.reached |-> rsp_data.parent == 5'd0 &&
        rsp_data.tree_weight == 16'd0)
        else $error("unreached vertex with parent or weight");

    // total only on the final word
    a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> rsp_data.total_weight == 21'd0)
        else $error("total on a non-final word");

    // vertex 0 is the root and never reported
    a_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.vertex != 5'd0)
        else $error("root vertex reported");

    // a start word blocks further input while the run goes on
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.operation == mstp_pkg::OP_START |=> req_stall)
        else $error("input taken right after start");

endmodule

bind max_spanning_tree_prim_top mstp_chk u_mstp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for max_spanning_tree_prim_top: loads edge words, starts
// tree runs and checks every tree edge word against an in-bench Prim predictor.
// Depends on mstp_pkg and the RTL of the engine only.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The clearing pass over the 1024-entry matrix follows reset and every run;
    // the margin on top covers the load compare-and-write stage.
    localparam int SETTLE_CYCLES = 1100;
    localparam int MAX_REPORTS   = 10;
    localparam int NV            = mstp_pkg::MAX_VERTICES;

    // ------------------------------------------------------------------
    // clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [mstp_pkg::PADDR_W-1:0] paddr     = '0;
    logic [mstp_pkg::PDATA_W-1:0] pwdata    = '0;
    logic [mstp_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    mstp_pkg::req_t               req_data  = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    mstp_pkg::rsp_t               rsp_data;

    always #5 clk = ~clk;

    max_spanning_tree_prim_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // ------------------------------------------------------------------
    // predictor state: its own copy of the matrix and the vertex count
    // ------------------------------------------------------------------
    bit             edge_on  [NV][NV];
    logic [15:0]    edge_wt  [NV][NV];
    logic [5:0]     vcount_reg = mstp_pkg::VCOUNT_RESET;
    mstp_pkg::rsp_t tree_edges_q[$];     // tree edge words still owed by the DUT

    // bookkeeping
    int err_count     = 0;
    int words_sent    = 0;
    int runs_started  = 0;
    int edges_checked = 0;
    int largest_run   = 0;

    // sender and receiver pacing state; quiet and stall_pct change only while the DUT is idle
    int burst_left = 0;
    bit quiet      = 1'b0;    // sender never pauses between words
    int stall_pct  = 20;      // chance that a new receiver stretch is a stall
    int stall_run  = 0;

    // vertex count in use: the register saturates to 2..MAX_VERTICES
    function automatic int vertices_in_use();
        int n;
        n = vcount_reg;
        if (n < 2)
        begin
            n = 2;
        end
        if (n > NV)
        begin
            n = NV;
        end
        return n;
    endfunction

    // Applies one accepted word. A load keeps the heavier of repeated edges;
    // a start grows the maximum tree from vertex 0 and queues n-1 tree edges.
    function automatic void predict_tree(input mstp_pkg::req_t w);
        int             n;
        int             a;
        int             b;
        int             pick;
        int             total;
        bit             found;
        bit             key_ok [NV];
        bit             done   [NV];
        logic [15:0]    key    [NV];
        int             par    [NV];
        mstp_pkg::rsp_t r;

        n = vertices_in_use();
        a = w.vertex_a;
        b = w.vertex_b;

        if (w.operation == mstp_pkg::OP_LOAD)
        begin
            // out-of-range endpoints and self loops leave the matrix alone
            if (a < n && b < n && a != b)
            begin
                if (!edge_on[a][b] || edge_wt[a][b] < w.edge_weight)
                begin
                    edge_on[a][b] = 1'b1;
                    edge_on[b][a] = 1'b1;
                    edge_wt[a][b] = w.edge_weight;
                    edge_wt[b][a] = w.edge_weight;
                end
            end
            return;
        end

        runs_started++;
        if (n - 1 > largest_run)
        begin
            largest_run = n - 1;
        end
        for (int i = 0; i < NV; i++)
        begin
            key_ok[i] = 1'b0;
            done[i]   = 1'b0;
            key[i]    = '0;
            par[i]    = 0;
        end
        key_ok[0] = 1'b1;

        found = 1'b1;
        while (found)
        begin
            // select: largest key among reached, unvisited vertices; lowest id on ties
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < n; i++)
            begin
                if (!done[i] && key_ok[i] && (!found || key[i] > key[pick]))
                begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found)
            begin
                done[pick] = 1'b1;
                // relax: raise keys of unvisited neighbours strictly
                for (int u = 0; u < n; u++)
                begin
                    if (edge_on[pick][u] && !done[u] &&
                        (!key_ok[u] || key[u] < edge_wt[pick][u]))
                    begin
                        key_ok[u] = 1'b1;
                        key[u]    = edge_wt[pick][u];
                        par[u]    = pick;
                    end
                end
            end
        end

        total = 0;
        for (int i = 1; i < n; i++)
        begin
            if (key_ok[i])
            begin
                total += key[i];
            end
            r.vertex       = i[4:0];
            r.parent       = key_ok[i] ? par[i][4:0] : 5'd0;
            r.tree_weight  = key_ok[i] ? key[i] : 16'd0;
            r.reached      = key_ok[i];
            r.total_weight = (i == n - 1) ? total[20:0] : 21'd0;
            r.last         = (i == n - 1);
            tree_edges_q   = {tree_edges_q, r};
        end

        // the DUT wipes its matrix after every run
        for (int i = 0; i < NV; i++)
        begin
            for (int j = 0; j < NV; j++)
            begin
                edge_on[i][j] = 1'b0;
                edge_wt[i][j] = '0;
            end
        end
    endfunction

    task automatic note_failure(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: every accepted tree edge against the oldest prediction
    // ------------------------------------------------------------------
    mstp_pkg::rsp_t want;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (tree_edges_q.size() == 0)
            begin
                note_failure($sformatf("unexpected tree edge word %p", rsp_data));
            end
            else
            begin
                want = tree_edges_q.pop_front();
                edges_checked++;
                if (rsp_data.vertex       !== want.vertex      ||
                    rsp_data.parent       !== want.parent      ||
                    rsp_data.tree_weight  !== want.tree_weight ||
                    rsp_data.reached      !== want.reached     ||
                    rsp_data.total_weight !== want.total_weight ||
                    rsp_data.last         !== want.last)
                begin
                    note_failure($sformatf(
                        "tree edge mismatch: expected %p, actual %p", want, rsp_data));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall stretches of random level and length
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_run > 0)
            begin
                stall_run <= stall_run - 1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
                stall_run <= $urandom_range(0, (stall_pct > 50) ? 12 : 3);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender: one word per call, in bursts with random gaps (skipped while quiet) between them
    // ------------------------------------------------------------------
    task automatic send_word(input mstp_pkg::req_t w);
        if (burst_left == 0)
        begin
            if (!quiet)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_data  <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        predict_tree(w);
        words_sent++;
    endtask

    task automatic load_edge(input int a, input int b, input int wt);
        mstp_pkg::req_t w;
        w.operation   = mstp_pkg::OP_LOAD;
        w.vertex_a    = a[4:0];
        w.vertex_b    = b[4:0];
        w.edge_weight = wt[15:0];
        send_word(w);
    endtask

    // start word; its endpoint and weight fields carry junk on purpose
    task automatic start_run(input int a, input int b, input int wt);
        mstp_pkg::req_t w;
        w.operation   = mstp_pkg::OP_START;
        w.vertex_a    = a[4:0];
        w.vertex_b    = b[4:0];
        w.edge_weight = wt[15:0];
        send_word(w);
    endtask

    // lets every owed tree edge arrive, then waits out the clearing pass
    task automatic wait_idle();
        req_valid  <= 1'b0;
        burst_left = 0;
        while (tree_edges_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of vertex_count, then a read back of the register
    task automatic write_vcount(input int value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mstp_pkg::ADDR_VCOUNT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        vcount_reg = value[5:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {{(mstp_pkg::PDATA_W-6){1'b0}}, vcount_reg})
        begin
            note_failure($sformatf("vertex_count read back: expected %0d, actual %0d",
                                   vcount_reg, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // Reset count of 32: extreme weights and vertex ids, a lighter and a
    // heavier repeat, a self loop, zero-weight edges, a three-way tie and an
    // unreachable component, so most vertices come back unreached.
    task automatic test_default_graph();
        load_edge(0, 31, 65535);
        load_edge(31, 0, 100);       // lighter repeat, 65535 stays
        load_edge(5, 5, 777);        // self loop
        load_edge(0, 1, 0);
        load_edge(1, 2, 0);
        load_edge(2, 1, 9);          // heavier repeat, given reversed
        load_edge(0, 3, 40);
        load_edge(0, 4, 40);
        load_edge(3, 4, 40);         // equal keys: lower id wins
        load_edge(30, 29, 16'hAAAA); // not connected to vertex 0
        start_run(31, 31, 65535);
    endtask

    // Saturating vertex count: 0 and 1 act as 2, 33 as 32; endpoints at or
    // above the count are dropped at load time.
    task automatic test_count_limits();
        write_vcount(0);
        load_edge(0, 1, 16'h5555);
        load_edge(1, 0, 16'hFFFF);
        load_edge(0, 2, 50);         // out of range for two vertices
        start_run(0, 0, 0);

        write_vcount(1);
        load_edge(1, 1, 123);
        start_run(21, 10, 16'h5A5A);

        write_vcount(33);
        start_run(0, 31, 1);         // empty matrix: all 31 unreached

        write_vcount(4);
        load_edge(0, 1, 7);
        load_edge(1, 2, 7);
        load_edge(2, 3, 7);
        load_edge(0, 3, 7);
        load_edge(3, 4, 9000);       // dropped, 4 is out of range
        start_run(16, 16, 0);
    endtask

    // ------------------------------------------------------------------
    // random graphs
    // ------------------------------------------------------------------

    // One graph: a batch of loads with random content, then a start word.
    // Mostly good edges, some repeats (reversed), self loops and endpoints
    // anywhere in 0..31; weight style chosen per graph to force ties or sums.
    task automatic run_graph(input int n);
        int loads;
        int kind;
        int style;
        int a;
        int b;
        int wt;
        int prev_a;
        int prev_b;
        style  = $urandom_range(0, 3);
        loads  = $urandom_range(1, (n < 14) ? 3 * n : 40);
        prev_a = 0;
        prev_b = 1;
        for (int k = 0; k < loads; k++)
        begin
            kind = $urandom_range(0, 99);
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            if (b == a)
            begin
                b = (a + 1) % n;
            end
            if (kind < 8 && k > 0)
            begin
                a = prev_b;
                b = prev_a;
            end
            else if (kind < 14)
            begin
                b = a;
            end
            else if (kind < 20)
            begin
                a = $urandom_range(0, 31);
                b = $urandom_range(0, 31);
            end
            case (style)
                0: wt = $urandom_range(0, 65535);
                1: wt = $urandom_range(0, 3);
                2: wt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 65535;
                default: wt = $urandom_range(0, 15);
            endcase
            load_edge(a, b, wt);
            prev_a = a;
            prev_b = b;
        end
        start_run($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 65535));
    endtask

    // Phases over several counts, extremes included; most graphs are small
    // since a run's cost grows with the vertex count, on top of the clearing pass.
    task automatic test_random_graphs();
        int counts[12];
        int phase_base;
        counts = '{2, 63, 5, 0, 12, 32, 1, 8, 33, 3, 20, 3};
        counts[9]  = $urandom_range(3, 31);
        counts[11] = $urandom_range(6, 30);
        for (int p = 0; p < 12; p++)
        begin
            write_vcount(counts[p]);
            quiet = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 60;
            endcase
            phase_base = words_sent;
            while (words_sent - phase_base < 20)
            begin
                run_graph(vertices_in_use());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NV; i++)
        begin
            for (int j = 0; j < NV; j++)
            begin
                edge_on[i][j] = 1'b0;
                edge_wt[i][j] = '0;
            end
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_default_graph();
        test_count_limits();
        test_random_graphs();

        // drain: every tree edge in, then the trailing clearing pass
        wait_idle();

        $display("Covered %0d words in %0d tree runs (largest %0d edges), vertex counts 0..63.",
                 words_sent, runs_started, largest_run);
        $display("Checked %0d tree edge words; %0d failures.", edges_checked, err_count);
        if (err_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run of this stimulus
    initial
    begin
        #100000000;
        $display("Timeout: %0d tree edges still owed.", tree_edges_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
